FILE: hdl/tftp_read_client_defines.svh
// assertion helpers for the tftp read client
`ifndef TFTP_READ_CLIENT_DEFINES_SVH
`define TFTP_READ_CLIENT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TRC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tftp_read_client check failed");

// next-cycle implication, checked out of reset
`define TRC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tftp_read_client check failed");

`endif

FILE: hdl/trc_pkg.sv
`timescale 1ns / 1ps

package trc_pkg;

  // block size limits
  localparam logic [10:0] MAX_BLOCK  = 11'd1428;
  localparam logic [10:0] DFLT_BLOCK = 11'd512;
  localparam logic [10:0] MIN_BLOCK  = 11'd8;
  localparam logic [10:0] HDR_BYTES  = 11'd4;

  // config register reset values
  localparam logic [31:0] RST_SERVER_ADDR = 32'd0;
  localparam logic [15:0] RST_SERVER_PORT = 16'd69;
  localparam logic [3:0]  RST_RETRY_LIMIT = 4'd5;
  localparam logic [9:0]  RST_STRAY_LIMIT = 10'd200;

  // config register indexes
  typedef enum logic [2:0] {
    REG_SERVER_ADDR = 3'd0,
    REG_SERVER_PORT = 3'd1,
    REG_REQ_BLKSIZE = 3'd2,
    REG_RETRY_LIMIT = 3'd3,
    REG_STRAY_LIMIT = 3'd4
  } reg_idx_t;

  // event codes
  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_PACKET  = 2'd1,
    CMD_TIMEOUT = 2'd2,
    CMD_ABORT   = 2'd3
  } cmd_t;

  // tftp opcodes of interest
  localparam logic [7:0] OPC_DATA  = 8'd3;
  localparam logic [7:0] OPC_ERROR = 8'd5;
  localparam logic [7:0] OPC_OACK  = 8'd6;

  // what to transmit
  localparam logic [1:0] SK_NONE = 2'd0;
  localparam logic [1:0] SK_REQ  = 2'd1;
  localparam logic [1:0] SK_ACK  = 2'd2;

  // transfer status
  localparam logic [2:0] ST_RUN     = 3'd0;
  localparam logic [2:0] ST_DONE    = 3'd1;
  localparam logic [2:0] ST_NORESP  = 3'd2;
  localparam logic [2:0] ST_TIMEOUT = 3'd3;
  localparam logic [2:0] ST_STRAYS  = 3'd4;
  localparam logic [2:0] ST_SRVERR  = 3'd5;
  localparam logic [2:0] ST_OVERSZ  = 3'd6;
  localparam logic [2:0] ST_ABORT   = 3'd7;

  // input word, first field in the highest bits
  typedef struct packed {
    logic [19:0] offered_blksize;
    logic [15:0] block_number;
    logic [7:0]  opcode;
    logic [10:0] packet_length;
    logic        addr_len_ok;
    logic [15:0] src_port;
    logic [31:0] src_addr;
  } in_item_t;

  // result word without send_kind, first field in the highest bits
  typedef struct packed {
    logic [10:0] agreed_blksize;
    logic [2:0]  status;
    logic [10:0] payload_length;
    logic        deliver_payload;
    logic [15:0] ack_block;
  } out_item_t;

endpackage

FILE: hdl/tftp_read_client.sv
`timescale 1ns / 1ps

// Receive-side TFTP read client state machine. Each input word is one event
// (start, received packet header, wait timeout, abort) and yields exactly one
// result word telling what to send, whether to keep the payload, the block
// size in force and the transfer status. One event is taken per clock while the
// output is not stalled: the event sits in an input register, its decision is one
// level of compares and counter updates, and the result is registered in the
// output register when that register is free or being taken. The output register
// stalls the input side only while it is full and not taken. Configuration writes
// are accepted every cycle and must only happen while no event is in flight.

`include "tftp_read_client_defines.svh"

module tftp_read_client (
  input  logic         clk,
  input  logic         rst_n,
  // event channel
  input  logic         in_tvalid,
  output logic         in_tready,
  // src_addr[31:0], src_port[47:32], addr_len_ok[48], packet_length[59:49],
  // opcode[67:60], block_number[83:68], offered_blksize[103:84]
  input  logic [103:0] in_tdata,
  // command[1:0]
  input  logic [1:0]   in_tuser,
  // result channel
  output logic         out_tvalid,
  input  logic         out_tready,
  // ack_block[15:0], deliver_payload[16], payload_length[27:17],
  // status[30:28], agreed_blksize[41:31], zero[47:42]
  output logic [47:0]  out_tdata,
  // send_kind[1:0]
  output logic [1:0]   out_tuser,
  // configuration writes
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_FIRST = 2'd1,
    PH_DATA  = 2'd2
  } phase_t;

  // config registers
  logic [31:0] server_addr_r;
  logic [15:0] server_port_r;
  logic [10:0] req_blksize_r;
  logic [3:0]  retry_limit_r;
  logic [9:0]  stray_limit_r;

  // transfer state
  phase_t      phase_r, phase_nxt;
  logic [15:0] peer_port_r, peer_port_nxt;
  logic [15:0] exp_block_r, exp_block_nxt;
  logic [10:0] block_size_r, block_size_nxt;
  logic [3:0]  retry_cnt_r, retry_cnt_nxt;
  logic [9:0]  stray_cnt_r, stray_cnt_nxt;

  // pipeline registers
  logic               in_vld_r;
  trc_pkg::in_item_t  in_r;
  trc_pkg::cmd_t      cmd_r;
  logic               out_vld_r;
  trc_pkg::out_item_t res_r, res_nxt;
  logic [1:0]         kind_r, kind_nxt;

  logic        adv;
  logic [10:0] payload;
  logic [10:0] req_clamped;
  logic [10:0] bs_eff;
  logic        pkt_ok;
  logic        first_data;

  // assertion helpers
  logic        term_step;
  logic        dlv_kind_ok;
  logic        bs_legal;

  assign cfg_ready  = 1'b1;
  assign adv        = !out_vld_r || out_tready;
  assign in_tready  = !in_vld_r || adv;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'd0, res_r};
  assign out_tuser  = kind_r;

  // requested size clamped to the legal range
  always_comb begin
    if (req_blksize_r < trc_pkg::MIN_BLOCK) begin
      req_clamped = trc_pkg::MIN_BLOCK;
    end else if (req_blksize_r > trc_pkg::MAX_BLOCK) begin
      req_clamped = trc_pkg::MAX_BLOCK;
    end else begin
      req_clamped = req_blksize_r;
    end
  end

  // packet checks shared by all packet paths
  assign payload    = in_r.packet_length - trc_pkg::HDR_BYTES;
  assign pkt_ok     = (in_r.packet_length >= trc_pkg::HDR_BYTES) && in_r.addr_len_ok &&
                      (in_r.src_addr == server_addr_r) &&
                      !(phase_r == PH_DATA && in_r.src_port != peer_port_r);
  assign first_data = (phase_r == PH_FIRST);
  assign bs_eff     = first_data ? trc_pkg::DFLT_BLOCK : block_size_r;

  // event decision
  always_comb begin
    phase_nxt      = phase_r;
    peer_port_nxt  = peer_port_r;
    exp_block_nxt  = exp_block_r;
    block_size_nxt = block_size_r;
    retry_cnt_nxt  = retry_cnt_r;
    stray_cnt_nxt  = stray_cnt_r;
    kind_nxt       = trc_pkg::SK_NONE;
    res_nxt        = '0;
    unique case (cmd_r)
      trc_pkg::CMD_START: begin
        phase_nxt      = PH_FIRST;
        peer_port_nxt  = server_port_r;
        exp_block_nxt  = 16'd1;
        block_size_nxt = req_clamped;
        retry_cnt_nxt  = '0;
        stray_cnt_nxt  = '0;
        kind_nxt       = trc_pkg::SK_REQ;
      end
      trc_pkg::CMD_ABORT: begin
        phase_nxt      = PH_IDLE;
        res_nxt.status = trc_pkg::ST_ABORT;
      end
      trc_pkg::CMD_TIMEOUT: begin
        if (phase_r == PH_IDLE) begin
          phase_nxt = PH_IDLE;
        end else if (retry_cnt_r >= retry_limit_r) begin
          phase_nxt      = PH_IDLE;
          res_nxt.status = first_data ? trc_pkg::ST_NORESP : trc_pkg::ST_TIMEOUT;
        end else begin
          retry_cnt_nxt = retry_cnt_r + 4'd1;
          if (first_data) begin
            kind_nxt = trc_pkg::SK_REQ;
          end else begin
            kind_nxt          = trc_pkg::SK_ACK;
            res_nxt.ack_block = exp_block_r - 16'd1;
          end
        end
      end
      trc_pkg::CMD_PACKET: begin
        if (phase_r == PH_IDLE) begin
          phase_nxt = PH_IDLE;
        end else if (!pkt_ok) begin
          // foreign or malformed packet
          if (stray_cnt_r >= stray_limit_r) begin
            phase_nxt      = PH_IDLE;
            res_nxt.status = trc_pkg::ST_STRAYS;
          end else begin
            stray_cnt_nxt = stray_cnt_r + 10'd1;
          end
        end else begin
          retry_cnt_nxt = '0;
          stray_cnt_nxt = '0;
          if (in_r.opcode == trc_pkg::OPC_ERROR) begin
            phase_nxt      = PH_IDLE;
            res_nxt.status = trc_pkg::ST_SRVERR;
          end else if (first_data && in_r.opcode == trc_pkg::OPC_OACK) begin
            // option ack may lower the block size
            peer_port_nxt = in_r.src_port;
            phase_nxt     = PH_DATA;
            kind_nxt      = trc_pkg::SK_ACK;
            if (in_r.offered_blksize >= 20'(trc_pkg::MIN_BLOCK) &&
                in_r.offered_blksize <= 20'(block_size_r)) begin
              block_size_nxt = in_r.offered_blksize[10:0];
            end
          end else if (in_r.opcode != trc_pkg::OPC_DATA) begin
            // first reply of another kind falls back to the default size
            if (first_data) begin
              peer_port_nxt  = in_r.src_port;
              phase_nxt      = PH_DATA;
              block_size_nxt = trc_pkg::DFLT_BLOCK;
              kind_nxt       = trc_pkg::SK_ACK;
            end
          end else begin
            // data block
            if (first_data) begin
              peer_port_nxt  = in_r.src_port;
              phase_nxt      = PH_DATA;
              block_size_nxt = trc_pkg::DFLT_BLOCK;
            end
            if (in_r.block_number != exp_block_r) begin
              kind_nxt          = trc_pkg::SK_ACK;
              res_nxt.ack_block = in_r.block_number;
            end else if (payload > bs_eff) begin
              phase_nxt      = PH_IDLE;
              res_nxt.status = trc_pkg::ST_OVERSZ;
            end else begin
              kind_nxt                = trc_pkg::SK_ACK;
              res_nxt.ack_block       = in_r.block_number;
              res_nxt.deliver_payload = (payload != 11'd0);
              res_nxt.payload_length  = payload;
              if (payload < bs_eff) begin
                phase_nxt      = PH_IDLE;
                res_nxt.status = trc_pkg::ST_DONE;
              end else begin
                exp_block_nxt = exp_block_r + 16'd1;
              end
            end
          end
        end
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase
    res_nxt.agreed_blksize = block_size_nxt;
  end

  // control and config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r      <= 1'b0;
      out_vld_r     <= 1'b0;
      server_addr_r <= trc_pkg::RST_SERVER_ADDR;
      server_port_r <= trc_pkg::RST_SERVER_PORT;
      req_blksize_r <= trc_pkg::MAX_BLOCK;
      retry_limit_r <= trc_pkg::RST_RETRY_LIMIT;
      stray_limit_r <= trc_pkg::RST_STRAY_LIMIT;
      phase_r       <= PH_IDLE;
      peer_port_r   <= '0;
      exp_block_r   <= 16'd1;
      block_size_r  <= trc_pkg::DFLT_BLOCK;
      retry_cnt_r   <= '0;
      stray_cnt_r   <= '0;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (adv) begin
        out_vld_r <= in_vld_r;
      end
      // state moves when the event's result is registered
      if (adv && in_vld_r) begin
        phase_r      <= phase_nxt;
        peer_port_r  <= peer_port_nxt;
        exp_block_r  <= exp_block_nxt;
        block_size_r <= block_size_nxt;
        retry_cnt_r  <= retry_cnt_nxt;
        stray_cnt_r  <= stray_cnt_nxt;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          trc_pkg::REG_SERVER_ADDR: server_addr_r <= cfg_data;
          trc_pkg::REG_SERVER_PORT: server_port_r <= cfg_data[15:0];
          trc_pkg::REG_REQ_BLKSIZE: req_blksize_r <= cfg_data[10:0];
          trc_pkg::REG_RETRY_LIMIT: retry_limit_r <= cfg_data[3:0];
          trc_pkg::REG_STRAY_LIMIT: stray_limit_r <= cfg_data[9:0];
          default: server_addr_r <= server_addr_r;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_r  <= trc_pkg::in_item_t'(in_tdata);
      cmd_r <= trc_pkg::cmd_t'(in_tuser);
    end
    if (adv && in_vld_r) begin
      res_r  <= res_nxt;
      kind_r <= kind_nxt;
    end
  end

  // terms used by the checks
  assign term_step   = adv && in_vld_r && (res_nxt.status != trc_pkg::ST_RUN);
  assign dlv_kind_ok = (kind_r == trc_pkg::SK_ACK) &&
                       (res_r.status == trc_pkg::ST_RUN || res_r.status == trc_pkg::ST_DONE);
  assign bs_legal    = (res_r.agreed_blksize >= trc_pkg::MIN_BLOCK) &&
                       (res_r.agreed_blksize <= trc_pkg::MAX_BLOCK);

  // checks
  `TRC_ASSERT_NOW(a_stall_holds_input, in_vld_r && out_vld_r && !out_tready, !in_tready)
  `TRC_ASSERT_NEXT(a_terminal_goes_idle, term_step, phase_r == PH_IDLE)
  `TRC_ASSERT_NOW(a_deliver_with_ack, out_vld_r && res_r.deliver_payload, dlv_kind_ok)
  `TRC_ASSERT_NOW(a_blksize_range, out_vld_r, bs_legal)

endmodule
